FILE: design/sliding_window_deque_aggregator_core_assert.svh
// Assertion macros used by the core design file.
`ifndef SLIDING_WINDOW_DEQUE_AGGREGATOR_CORE_ASSERT_SVH
`define SLIDING_WINDOW_DEQUE_AGGREGATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SWDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SWDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/swda_pkg.sv
// Types, codes and the combine function of the deque aggregator.
package swda_pkg;

  localparam int DefWindowDepth = 64;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  localparam logic [1:0] MODE_LEFT = 2'd0;
  localparam logic [1:0] MODE_MIN  = 2'd1;
  localparam logic [1:0] MODE_MAX  = 2'd2;
  localparam logic [1:0] MODE_SUM  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_PUSH_WR, S_MV_RD, S_MV_WR, S_SH_RD, S_SH_WR, S_FIX,
    S_LF_RD, S_LF_WR, S_RF_RD, S_RF_WR, S_POP, S_RD_TOP, S_RD_BOT, S_RESP
  } state_t;

  // x comes before y in window order
  function automatic logic signed [63:0] combine(input logic [1:0] mode,
                                                 input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [63:0] r;
    unique case (mode)
      MODE_MIN: r = (x <= y) ? x : y;
      MODE_MAX: r = (x >= y) ? x : y;
      MODE_SUM: r = x + y;
      default:  r = x;
    endcase
    return r;
  endfunction

endpackage

FILE: design/sliding_window_deque_aggregator_core.sv
// Sliding-window deque aggregator: two fold stacks with a shared combine unit.
//
// Input channel s_*: s_tuser carries the opcode (push front/back, pop
// front/back, read), s_tdata the 64-bit signed value to push. Output channel
// m_*: one result item per input item with front, back, ordered aggregate,
// count, empty flag and error code. fold_mode is written through cfg_we and
// cfg_wdata; write it only while the block is idle, the block does not enforce it.
// Sequence: a read goes through RD_TOP, RD_BOT and RESP after accept; a pop that
// needs no rebuild goes through POP first, a push through PUSH and PUSH_WR;
// the block returns to idle once the result is loaded. A pop from an empty side
// rebuilds: it moves and shifts the n entries of the other stack, then refolds
// both stacks entry by entry; every step is one read and one write per stack
// memory through a single combine unit. The block takes one item at a time and
// is not ready until the result sits in the output register.
// Reset clears the counts, fold_mode and the output valid; the stack memories
// are not cleared, as only entries below the counts are ever used in a result.
// When the receiver stalls the result holds in the output register; the next
// item is accepted meanwhile and waits at its result stage until it drains.
module sliding_window_deque_aggregator_core #(
  parameter int WINDOW_DEPTH = swda_pkg::DefWindowDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // value[63:0]
  input  logic [2:0]   s_tuser,   // opcode[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // front_value[63:0], back_value[127:64], aggregate[191:128], count[198:192],
  // is_empty[199], error[201:200], zero pad[207:202]
  output logic [207:0] m_tdata
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] DEPTH = CW'(WINDOW_DEPTH);

  swda_pkg::state_t state, state_next;

  logic [1:0]         fold_mode;
  logic [2:0]         op;
  logic signed [63:0] val;
  logic [1:0]         err;
  logic [CW-1:0]      lc, rc, idx, reb_m, reb_r;
  logic               reb_left;
  logic signed [63:0] acc, ltopv, ltopf, rtopv, rtopf;

  logic signed [63:0] lv_mem [WINDOW_DEPTH];
  logic signed [63:0] lf_mem [WINDOW_DEPTH];
  logic signed [63:0] rv_mem [WINDOW_DEPTH];
  logic signed [63:0] rf_mem [WINDOW_DEPTH];
  logic signed [63:0] lv_rd, lf_rd, rv_rd, rf_rd;
  logic [AW-1:0]      lv_ra, lf_ra, rv_ra, rf_ra;
  logic [AW-1:0]      lv_wa, lf_wa, rv_wa, rf_wa;
  logic signed [63:0] lv_wd, lf_wd, rv_wd, rf_wd;
  logic               lv_we, lf_we, rv_we, rf_we;

  logic signed [63:0] cx, cy, cres, fold_res, src_rd;
  logic [CW-1:0]      total, lc_m1, rc_m1, mv_src, sh_src, src_n;
  logic               accept, out_free, idx_last_mv, idx_last_sh;
  logic               idx_last_l, idx_last_r;
  logic signed [63:0] o_front, o_back, o_agg;

  assign total    = CW'(lc + rc);
  assign lc_m1    = lc - ONE;
  assign rc_m1    = rc - ONE;
  assign mv_src   = reb_m - ONE - idx;
  assign sh_src   = reb_m + idx;
  assign src_n    = (s_tuser == swda_pkg::OP_POP_FRONT) ? rc : lc;
  assign s_tready = (state == swda_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign src_rd   = reb_left ? rv_rd : lv_rd;
  assign idx_last_mv = (idx + ONE == reb_m);
  assign idx_last_sh = (idx + ONE == reb_r);
  assign idx_last_l  = (idx + ONE == lc);
  assign idx_last_r  = (idx + ONE == rc);

  // shared combine unit
  assign cres = swda_pkg::combine(fold_mode, cx, cy);

  always_comb begin
    state_next = state;
    unique case (state)
      swda_pkg::S_IDLE: begin
        if (s_tvalid) begin
          priority if (s_tuser == swda_pkg::OP_PUSH_FRONT ||
                       s_tuser == swda_pkg::OP_PUSH_BACK) begin
            state_next = (total == DEPTH) ? swda_pkg::S_RD_TOP : swda_pkg::S_PUSH;
          end else if (s_tuser == swda_pkg::OP_POP_FRONT ||
                       s_tuser == swda_pkg::OP_POP_BACK) begin
            if (total == '0) state_next = swda_pkg::S_RD_TOP;
            else if (s_tuser == swda_pkg::OP_POP_FRONT)
              state_next = (lc == '0) ? swda_pkg::S_MV_RD : swda_pkg::S_POP;
            else
              state_next = (rc == '0) ? swda_pkg::S_MV_RD : swda_pkg::S_POP;
          end else begin
            state_next = swda_pkg::S_RD_TOP;
          end
        end
      end
      swda_pkg::S_PUSH:    state_next = swda_pkg::S_PUSH_WR;
      swda_pkg::S_PUSH_WR: state_next = swda_pkg::S_RD_TOP;
      swda_pkg::S_MV_RD:   state_next = swda_pkg::S_MV_WR;
      swda_pkg::S_MV_WR: begin
        if (!idx_last_mv) state_next = swda_pkg::S_MV_RD;
        else state_next = (reb_r == '0) ? swda_pkg::S_FIX : swda_pkg::S_SH_RD;
      end
      swda_pkg::S_SH_RD:   state_next = swda_pkg::S_SH_WR;
      swda_pkg::S_SH_WR:
        state_next = idx_last_sh ? swda_pkg::S_FIX : swda_pkg::S_SH_RD;
      swda_pkg::S_FIX: begin
        // the destination side is never empty; the left may be the source
        state_next = (reb_left || reb_r != '0) ? swda_pkg::S_LF_RD : swda_pkg::S_RF_RD;
      end
      swda_pkg::S_LF_RD:   state_next = swda_pkg::S_LF_WR;
      swda_pkg::S_LF_WR: begin
        if (!idx_last_l) state_next = swda_pkg::S_LF_RD;
        else state_next = (rc == '0) ? swda_pkg::S_POP : swda_pkg::S_RF_RD;
      end
      swda_pkg::S_RF_RD:   state_next = swda_pkg::S_RF_WR;
      swda_pkg::S_RF_WR:
        state_next = idx_last_r ? swda_pkg::S_POP : swda_pkg::S_RF_RD;
      swda_pkg::S_POP:     state_next = swda_pkg::S_RD_TOP;
      swda_pkg::S_RD_TOP:  state_next = swda_pkg::S_RD_BOT;
      swda_pkg::S_RD_BOT:  state_next = swda_pkg::S_RESP;
      swda_pkg::S_RESP:    if (out_free) state_next = swda_pkg::S_IDLE;
      default:             state_next = swda_pkg::S_IDLE;
    endcase
  end

  // memory addressing and combine operands per step
  always_comb begin
    lv_ra = '0; lf_ra = '0; rv_ra = '0; rf_ra = '0;
    lv_wa = '0; lf_wa = '0; rv_wa = '0; rf_wa = '0;
    lv_we = 1'b0; lf_we = 1'b0; rv_we = 1'b0; rf_we = 1'b0;
    lv_wd = val; rv_wd = val; lf_wd = fold_res; rf_wd = fold_res;
    cx = ltopf; cy = rtopf;
    fold_res = cres;
    unique case (state)
      swda_pkg::S_PUSH: begin
        lf_ra = lc_m1[AW-1:0];
        rf_ra = rc_m1[AW-1:0];
      end
      swda_pkg::S_PUSH_WR: begin
        if (op == swda_pkg::OP_PUSH_FRONT) begin
          cx = val; cy = lf_rd;
          fold_res = (lc == '0) ? val : cres;
          lv_we = 1'b1; lv_wa = lc[AW-1:0];
          lf_we = 1'b1; lf_wa = lc[AW-1:0];
        end else begin
          cx = rf_rd; cy = val;
          fold_res = (rc == '0) ? val : cres;
          rv_we = 1'b1; rv_wa = rc[AW-1:0];
          rf_we = 1'b1; rf_wa = rc[AW-1:0];
        end
      end
      swda_pkg::S_MV_RD: begin
        lv_ra = mv_src[AW-1:0];
        rv_ra = mv_src[AW-1:0];
      end
      swda_pkg::S_MV_WR: begin
        lv_wd = src_rd; rv_wd = src_rd;
        lv_wa = idx[AW-1:0]; rv_wa = idx[AW-1:0];
        lv_we = reb_left; rv_we = !reb_left;
      end
      swda_pkg::S_SH_RD: begin
        lv_ra = sh_src[AW-1:0];
        rv_ra = sh_src[AW-1:0];
      end
      swda_pkg::S_SH_WR: begin
        lv_wd = src_rd; rv_wd = src_rd;
        lv_wa = idx[AW-1:0]; rv_wa = idx[AW-1:0];
        lv_we = !reb_left; rv_we = reb_left;
      end
      swda_pkg::S_LF_RD: lv_ra = idx[AW-1:0];
      swda_pkg::S_LF_WR: begin
        cx = lv_rd; cy = acc;
        fold_res = (idx == '0) ? lv_rd : cres;
        lf_we = 1'b1; lf_wa = idx[AW-1:0];
      end
      swda_pkg::S_RF_RD: rv_ra = idx[AW-1:0];
      swda_pkg::S_RF_WR: begin
        cx = acc; cy = rv_rd;
        fold_res = (idx == '0) ? rv_rd : cres;
        rf_we = 1'b1; rf_wa = idx[AW-1:0];
      end
      swda_pkg::S_RD_TOP: begin
        lv_ra = lc_m1[AW-1:0]; lf_ra = lc_m1[AW-1:0];
        rv_ra = rc_m1[AW-1:0]; rf_ra = rc_m1[AW-1:0];
      end
      default: ;  // bottoms stay addressed at entry zero
    endcase
  end

  // result fields; in S_RESP the value read data hold the stack bottoms
  always_comb begin
    o_front = '0; o_back = '0; o_agg = '0;
    if (total != '0) begin
      o_front = (lc != '0) ? ltopv : rv_rd;
      o_back  = (rc != '0) ? rtopv : lv_rd;
      if (lc == '0)      o_agg = rtopf;
      else if (rc == '0) o_agg = ltopf;
      else               o_agg = cres;
    end
  end

  always_ff @(posedge clk) begin
    if (lv_we) lv_mem[lv_wa] <= lv_wd;
    if (lf_we) lf_mem[lf_wa] <= lf_wd;
    if (rv_we) rv_mem[rv_wa] <= rv_wd;
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    lv_rd <= lv_mem[lv_ra];
    lf_rd <= lf_mem[lf_ra];
    rv_rd <= rv_mem[rv_ra];
    rf_rd <= rf_mem[rf_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swda_pkg::S_IDLE;
      fold_mode <= swda_pkg::MODE_LEFT;
      lc        <= '0;
      rc        <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) fold_mode <= cfg_wdata;
      if (state == swda_pkg::S_RESP && out_free) m_tvalid <= 1'b1;
      else if (m_tready)                          m_tvalid <= 1'b0;
      unique case (state)
        swda_pkg::S_PUSH_WR: begin
          if (op == swda_pkg::OP_PUSH_FRONT) lc <= lc + ONE;
          else                               rc <= rc + ONE;
        end
        swda_pkg::S_FIX: begin
          lc <= reb_left ? reb_m : reb_r;
          rc <= reb_left ? reb_r : reb_m;
        end
        swda_pkg::S_POP: begin
          if (op == swda_pkg::OP_POP_FRONT) lc <= lc_m1;
          else                              rc <= rc_m1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      swda_pkg::S_IDLE: begin
        if (accept) begin
          op       <= s_tuser;
          val      <= s_tdata;
          idx      <= '0;
          reb_left <= (s_tuser == swda_pkg::OP_POP_FRONT);
          reb_m    <= src_n - (src_n >> 1);
          reb_r    <= src_n >> 1;
          if ((s_tuser == swda_pkg::OP_PUSH_FRONT || s_tuser == swda_pkg::OP_PUSH_BACK)
              && total == DEPTH)
            err <= swda_pkg::ERR_FULL;
          else if ((s_tuser == swda_pkg::OP_POP_FRONT || s_tuser == swda_pkg::OP_POP_BACK)
                   && total == '0)
            err <= swda_pkg::ERR_EMPTY;
          else
            err <= swda_pkg::ERR_NONE;
        end
      end
      swda_pkg::S_MV_WR: idx <= idx_last_mv ? '0 : idx + ONE;
      swda_pkg::S_SH_WR: idx <= idx_last_sh ? '0 : idx + ONE;
      swda_pkg::S_FIX:   idx <= '0;
      swda_pkg::S_LF_WR: begin
        acc <= fold_res;
        idx <= idx_last_l ? '0 : idx + ONE;
      end
      swda_pkg::S_RF_WR: begin
        acc <= fold_res;
        idx <= idx_last_r ? '0 : idx + ONE;
      end
      swda_pkg::S_RD_BOT: begin
        ltopv <= lv_rd; ltopf <= lf_rd;
        rtopv <= rv_rd; rtopf <= rf_rd;
      end
      swda_pkg::S_RESP: begin
        if (out_free)
          m_tdata <= {6'd0, err, (total == '0), 7'(total), o_agg, o_back, o_front};
      end
      default: ;
    endcase
  end

`include "sliding_window_deque_aggregator_core_assert.svh"

  `SWDA_ASSERT_NOW(a_count_bound, 1'b1, total <= DEPTH, "window count beyond depth")
  `SWDA_ASSERT_NEXT(a_accept_busy, accept, state != swda_pkg::S_IDLE, "item accepted but idle")
  `SWDA_ASSERT_NOW(a_pop_nonempty, state == swda_pkg::S_POP,
    (op == swda_pkg::OP_POP_FRONT) ? (lc != '0) : (rc != '0), "pop from empty stack")
  `SWDA_ASSERT_NOW(a_full_err, state == swda_pkg::S_RESP && err == swda_pkg::ERR_FULL,
    total == DEPTH, "full error with room left")

endmodule
